// ===== hdl/ctd_pkg.sv =====
// Shared types and constants for the chunked transfer decoder.
package ctd_pkg;

  localparam int SIZE_BITS  = 32;
  localparam int MAX_DIGITS = SIZE_BITS / 4;
  localparam int DC_W       = 4;
  localparam int TOTAL_W    = 32;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = FIFO_AW + 1;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;
  localparam logic [1:0] KIND_TRAILER = 2'd3;

  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;

  typedef struct packed {
    logic [7:0] data;
    logic       is_cr;
    logic       is_lf;
    logic       is_hex;
    logic [3:0] hex_val;
  } ctd_item_t;

endpackage

// ===== hdl/ctd_front.sv =====
// Front end: takes input beats and classifies each byte for the back end.
module ctd_front (
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic                q_full,
  output logic                q_push,
  output ctd_pkg::ctd_item_t  q_item
);
  import ctd_pkg::*;

  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
    return r;
  endfunction

  logic [4:0] hx;

  always_comb begin
    hx             = hex_decode(in_tdata);
    q_item.data    = in_tdata;
    q_item.is_cr   = (in_tdata == CH_CR);
    q_item.is_lf   = (in_tdata == CH_LF);
    q_item.is_hex  = ~hx[4];
    q_item.hex_val = hx[3:0];
  end

  assign in_tready = ~q_full;
  assign q_push    = in_tvalid & ~q_full;

endmodule

// ===== hdl/ctd_fifo.sv =====
// Short queue of classified bytes between front and back end.
module ctd_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ctd_pkg::ctd_item_t  push_item,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output ctd_pkg::ctd_item_t  pop_item
);
  import ctd_pkg::*;

  ctd_item_t            mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0]   count_r, count_nxt;

  assign full      = (count_r == FIFO_CW'(FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + FIFO_CW'(push) - FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== hdl/ctd_back.sv =====
// Back end: chunk framing state machine and output register.
module ctd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  ctd_pkg::ctd_item_t  q_item,
  output logic                q_pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [39:0]         out_tdata,
  output logic [1:0]          out_tuser
);
  import ctd_pkg::*;

  localparam logic [2:0] PH_BEGIN = 3'd0;
  localparam logic [2:0] PH_FCR   = 3'd1;
  localparam logic [2:0] PH_FLF   = 3'd2;
  localparam logic [2:0] PH_DATA  = 3'd3;
  localparam logic [2:0] PH_SCR   = 3'd4;
  localparam logic [2:0] PH_SLF   = 3'd5;

  logic [2:0]           phase_r, phase_nxt;
  logic [SIZE_BITS-1:0] size_accum_r, size_accum_nxt;
  logic                 closed_r, closed_nxt;
  logic [DC_W-1:0]      digit_count_r, digit_count_nxt;
  logic [31:0]          bytes_left_r, bytes_left_nxt;
  logic                 last_chunk_r, last_chunk_nxt;
  logic                 in_trailer_r, in_trailer_nxt;
  logic                 finished_r, finished_nxt;
  logic [TOTAL_W-1:0]   total_r, total_nxt;

  logic                 out_valid_r;
  logic [1:0]           out_kind_r;
  logic [7:0]           out_byte_r;
  logic [TOTAL_W-1:0]   out_total_r;

  logic                 res_valid;
  logic [1:0]           res_kind;
  logic [7:0]           res_byte;
  logic                 go;
  logic [2:0]           ph;
  logic [TOTAL_W:0]     sum;

  assign q_pop = q_valid & (~out_valid_r | out_tready);

  always_comb begin
    phase_nxt       = phase_r;
    size_accum_nxt  = size_accum_r;
    closed_nxt      = closed_r;
    digit_count_nxt = digit_count_r;
    bytes_left_nxt  = bytes_left_r;
    last_chunk_nxt  = last_chunk_r;
    in_trailer_nxt  = in_trailer_r;
    finished_nxt    = finished_r;
    total_nxt       = total_r;
    res_valid       = 1'b0;
    res_kind        = KIND_PAYLOAD;
    res_byte        = 8'd0;
    go              = 1'b0;
    ph              = phase_r;
    sum             = {1'b0, total_r} + {1'b0, TOTAL_W'(size_accum_r)};

    if (finished_r) begin
      go = 1'b0;
    end else if (in_trailer_r) begin
      res_valid = 1'b1;
      res_kind  = KIND_TRAILER;
      res_byte  = q_item.data;
    end else if (bytes_left_r != '0) begin
      bytes_left_nxt = bytes_left_r - 32'd1;
      res_valid      = 1'b1;
      res_kind       = KIND_PAYLOAD;
      res_byte       = q_item.data;
    end else begin
      go = 1'b1;
      if (phase_r == PH_FLF) begin
        if (digit_count_r == '0 || digit_count_r > DC_W'(MAX_DIGITS)) begin
          finished_nxt = 1'b1;
          res_valid    = 1'b1;
          res_kind     = KIND_ERROR;
          go           = 1'b0;
        end else if (size_accum_r != '0) begin
          total_nxt       = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
          bytes_left_nxt  = 32'(size_accum_r) - 32'd1;
          size_accum_nxt  = '0;
          closed_nxt      = 1'b0;
          digit_count_nxt = '0;
          ph              = PH_DATA;
          res_valid       = 1'b1;
          res_kind        = KIND_PAYLOAD;
          res_byte        = q_item.data;
          go              = 1'b0;
        end else begin
          last_chunk_nxt = 1'b1;
          ph             = PH_DATA;
          if (!q_item.is_cr && !q_item.is_lf) begin
            in_trailer_nxt = 1'b1;
            res_valid      = 1'b1;
            res_kind       = KIND_TRAILER;
            res_byte       = q_item.data;
            go             = 1'b0;
          end
        end
      end
      if (go) begin
        if (ph == PH_SLF) ph = PH_BEGIN;
        if (q_item.is_cr) begin
          ph = (ph == PH_DATA) ? PH_SCR : PH_FCR;
        end else if (q_item.is_lf) begin
          if (ph == PH_SCR) begin
            ph = PH_SLF;
            if (last_chunk_nxt) begin
              finished_nxt = 1'b1;
              res_valid    = 1'b1;
              res_kind     = KIND_END;
            end
          end else begin
            ph = PH_FLF;
          end
        end else if (!closed_r) begin
          if (q_item.is_hex) begin
            if (digit_count_r < DC_W'(MAX_DIGITS)) begin
              size_accum_nxt  = {size_accum_r[SIZE_BITS-5:0], q_item.hex_val};
              digit_count_nxt = digit_count_r + 1'b1;
            end else begin
              digit_count_nxt = DC_W'(MAX_DIGITS + 1);
            end
          end else begin
            closed_nxt = 1'b1;
          end
        end
      end
    end
    phase_nxt = ph;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_BEGIN;
      size_accum_r  <= '0;
      closed_r      <= 1'b0;
      digit_count_r <= '0;
      bytes_left_r  <= '0;
      last_chunk_r  <= 1'b0;
      in_trailer_r  <= 1'b0;
      finished_r    <= 1'b0;
      total_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r       <= phase_nxt;
        size_accum_r  <= size_accum_nxt;
        closed_r      <= closed_nxt;
        digit_count_r <= digit_count_nxt;
        bytes_left_r  <= bytes_left_nxt;
        last_chunk_r  <= last_chunk_nxt;
        in_trailer_r  <= in_trailer_nxt;
        finished_r    <= finished_nxt;
        total_r       <= total_nxt;
        out_valid_r   <= res_valid;
      end else if (out_tready) begin
        out_valid_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && res_valid) begin
      out_kind_r  <= res_kind;
      out_byte_r  <= res_byte;
      out_total_r <= total_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_total_r, out_byte_r};
  assign out_tuser  = out_kind_r;

  a_finished_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |=> finished_r)
    else $error("finished flag cleared");

  a_trailer_not_finished: assert property (@(posedge clk) disable iff (!rst_n)
    in_trailer_r |-> !finished_r)
    else $error("trailer and finished both set");

  a_payload_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    (bytes_left_r != '0) |-> (phase_r == PH_DATA))
    else $error("payload countdown outside data phase");

  a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    digit_count_r <= DC_W'(MAX_DIGITS + 1))
    else $error("digit count out of range");

endmodule

// ===== hdl/chunked_transfer_decoder.sv =====
// Chunked transfer decoder top level: one body byte in, zero or one result out.
//
// Accepts one raw byte of a chunk-encoded body per cycle unless the queue is
// full, and removes the framing. Results are payload bytes, trailer bytes, a
// message end and a framing error, each with the running total of announced
// chunk sizes. Throughput is one byte per cycle, set by the framing state
// machine in the back end, which consumes one queued byte per cycle while its
// output register is empty or being read. A four-entry queue between the
// byte classifier and the state machine keeps input accepted while a result
// waits. After a message end or framing error all bytes are dropped until reset.
module chunked_transfer_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] out_byte, [39:8] total_len
  output logic [1:0]  out_tuser   // [1:0] kind
);
  import ctd_pkg::*;

  ctd_item_t push_item;
  ctd_item_t pop_item;
  logic      q_full;
  logic      q_push;
  logic      q_pop;
  logic      q_valid;

  ctd_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  ctd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_item  (pop_item)
  );

  ctd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (pop_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
